// File: hw/rtl/gabt_pkg.sv
// shared types and constants for the fixed-point matrix multiply block
package gabt_pkg;

   localparam int MAX_DIM_DEF = 16;
   localparam int ELEM_W = 16;
   localparam int SCALE_W = 16;
   localparam int DIM_W = 5;
   localparam int OP_W = 3;
   localparam int IDX_W = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_A  = 3'd0,
      OP_LOAD_B  = 3'd1,
      OP_LOAD_C  = 3'd2,
      OP_COMPUTE = 3'd3,
      OP_READ_C  = 3'd4
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRANSPOSE_A = 3'd0,
      CSR_TRANSPOSE_B = 3'd1,
      CSR_ROWS_M      = 3'd2,
      CSR_COLS_N      = 3'd3,
      CSR_INNER_K     = 3'd4,
      CSR_ALPHA       = 3'd5,
      CSR_BETA        = 3'd6
   } csr_type;

   localparam logic RESULT_DONE = 1'b0;
   localparam logic RESULT_READ = 1'b1;

   // saturate a wide signed sum into one element
   function automatic logic signed [ELEM_W-1:0] sat_elem(input logic signed [47:0] v);
      logic signed [47:0] hi;
      logic signed [47:0] lo;
      hi = 48'sd32767;
      lo = -48'sd32768;
      if (v > hi) sat_elem = 16'sh7fff;
      else if (v < lo) sat_elem = 16'sh8000;
      else sat_elem = v[ELEM_W-1:0];
   endfunction

endpackage

// File: hw/rtl/gabt_ram.sv
// generic single-port-write, one-read ram with registered read data
module gabt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// File: hw/rtl/gabt_mac.sv
// multiply-accumulate and scaling datapath for one output element
module gabt_mac (
   input  logic                                   clock,
   input  logic                                   acc_clear,
   input  logic                                   acc_en,
   input  logic signed [gabt_pkg::ELEM_W-1:0]     a_value,
   input  logic signed [gabt_pkg::ELEM_W-1:0]     b_value,
   input  logic                                   scale_en,
   input  logic signed [gabt_pkg::SCALE_W-1:0]    alpha_scale,
   input  logic signed [gabt_pkg::SCALE_W-1:0]    beta_scale,
   input  logic signed [gabt_pkg::ELEM_W-1:0]     c_old,
   input  logic                                   sum_en,
   output logic signed [gabt_pkg::ELEM_W-1:0]     c_new
);
   import gabt_pkg::*;

   logic signed [31:0] prod_ff;
   logic               prod_vld_ff;
   logic signed [39:0] acc_ff;
   logic signed [55:0] alpha_prod_ff;
   logic signed [31:0] beta_prod_ff;
   logic signed [47:0] alpha_rnd;
   logic signed [47:0] beta_rnd;
   logic signed [47:0] sum_in;

   // product is registered, then summed into the accumulator in the next cycle; scale products register on scale_en
   always_ff @(posedge clock) begin
      prod_ff <= a_value * b_value;
      prod_vld_ff <= acc_en;
      if (acc_clear) acc_ff <= '0;
      else if (prod_vld_ff) acc_ff <= acc_ff + 40'(prod_ff);
      if (scale_en) begin
         alpha_prod_ff <= 56'(alpha_scale) * 56'(acc_ff);
         beta_prod_ff <= (beta_scale == '0) ? '0 : 32'(beta_scale) * 32'(c_old);
      end
   end

   // arithmetic shifts give floor, matching round-half-up
   always_comb begin
      alpha_rnd = 48'((alpha_prod_ff + 56'sd524288) >>> 20);
      beta_rnd = 48'((48'(beta_prod_ff) + 48'sd2048) >>> 12);
      sum_in = alpha_rnd + beta_rnd;
   end

   always_ff @(posedge clock) begin
      if (sum_en) c_new <= sat_elem(sum_in);
   end
endmodule

// File: hw/rtl/gemm_alpha_beta_transpose.sv
// top level: matrix stores, compute sequencer and request/response channels
// loads write their store when accepted; a read answers through pend_ff and the response registers.
// compute walks i, j and p with one A/B memory read per cycle, then raises
// the done word; each store has a single read port.
// reset (synchronous, active high) restores the CSR and control registers (not the response
// data) and idles the sequencer; store contents are undefined until written.
module gemm_alpha_beta_transpose (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [gabt_pkg::OP_W-1:0]            req_operation,
   input  logic [gabt_pkg::IDX_W-1:0]           req_row_index,
   input  logic [gabt_pkg::IDX_W-1:0]           req_col_index,
   input  logic signed [gabt_pkg::ELEM_W-1:0]   req_element_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_result_kind,
   output logic signed [gabt_pkg::ELEM_W-1:0]   rsp_result_value,
   input  logic                                 csr_write,
   input  logic [gabt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gabt_pkg::CSR_DATA_W-1:0]      csr_data
);
   import gabt_pkg::*;

   localparam int MAX_DIM = MAX_DIM_DEF;
   localparam int DW = $clog2(MAX_DIM);
   localparam int AW = 2 * DW;
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int CW = $clog2(MAX_DIM + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_MAC, ST_DRAIN, ST_ACCW, ST_SCALE, ST_SUM, ST_WRITE, ST_RESP
   } state_type;

   state_type state_ff;
   logic              ta_ff, tb_ff;
   logic [DIM_W-1:0]  rows_ff, cols_ff, inner_ff;
   logic signed [SCALE_W-1:0] alpha_ff, beta_ff;
   logic [DW-1:0]     i_ff, j_ff, p_ff;
   logic [CW-1:0]     m_lim, n_lim, k_lim;
   logic              rsp_valid_ff, rsp_kind_ff, read_zero_ff;
   logic signed [ELEM_W-1:0] rsp_value_ff;
   logic              pend_ff;

   logic              accept, in_range;
   logic [AW-1:0]     req_addr, a_addr, b_addr, c_addr, c_rd_addr;
   logic [ELEM_W-1:0] a_rd, b_rd, c_rd;
   logic signed [ELEM_W-1:0] c_new;
   logic              wr_a, wr_b, wr_c;
   logic [AW-1:0]     c_wr_addr;
   logic [ELEM_W-1:0] c_wr_data;
   logic              acc_clear, acc_en, scale_en, sum_en;
   logic              last_p, last_j, last_i;

   function automatic logic [CW-1:0] clamp(input logic [DIM_W-1:0] d);
      if (d == '0) clamp = CW'(1);
      else if (32'(d) > MAX_DIM) clamp = CW'(MAX_DIM);
      else clamp = CW'(d);
   endfunction

   assign m_lim = clamp(rows_ff);
   assign n_lim = clamp(cols_ff);
   assign k_lim = clamp(inner_ff);

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall) || pend_ff;
   assign accept = req_valid && !req_stall;
   assign in_range = (32'(req_row_index) < MAX_DIM) && (32'(req_col_index) < MAX_DIM);
   assign req_addr = {req_row_index[DW-1:0], req_col_index[DW-1:0]};

   assign a_addr = ta_ff ? {p_ff, i_ff} : {i_ff, p_ff};
   assign b_addr = tb_ff ? {j_ff, p_ff} : {p_ff, j_ff};
   assign c_addr = {i_ff, j_ff};
   assign c_rd_addr = (state_ff == ST_IDLE) ? req_addr : c_addr;

   assign wr_a = accept && in_range && (op_type'(req_operation) == OP_LOAD_A);
   assign wr_b = accept && in_range && (op_type'(req_operation) == OP_LOAD_B);
   assign wr_c = (accept && in_range && (op_type'(req_operation) == OP_LOAD_C))
                 || (state_ff == ST_WRITE);
   assign c_wr_addr = (state_ff == ST_WRITE) ? c_addr : req_addr;
   assign c_wr_data = (state_ff == ST_WRITE) ? c_new : req_element_value;

   assign last_p = (CW'(p_ff) == k_lim - CW'(1));
   assign last_j = (CW'(j_ff) == n_lim - CW'(1));
   assign last_i = (CW'(i_ff) == m_lim - CW'(1));

   assign acc_clear = (state_ff == ST_IDLE) || (state_ff == ST_WRITE);
   assign acc_en = (state_ff == ST_MAC) || (state_ff == ST_DRAIN);
   assign scale_en = (state_ff == ST_SCALE);
   assign sum_en = (state_ff == ST_SUM);

   gabt_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_a (
      .clock(clock), .wr_en(wr_a), .wr_addr(req_addr), .wr_data(req_element_value),
      .rd_addr(a_addr), .rd_data(a_rd));
   gabt_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_b (
      .clock(clock), .wr_en(wr_b), .wr_addr(req_addr), .wr_data(req_element_value),
      .rd_addr(b_addr), .rd_data(b_rd));
   gabt_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_c (
      .clock(clock), .wr_en(wr_c), .wr_addr(c_wr_addr), .wr_data(c_wr_data),
      .rd_addr(c_rd_addr), .rd_data(c_rd));

   gabt_mac u_mac (
      .clock(clock), .acc_clear(acc_clear), .acc_en(acc_en),
      .a_value(a_rd), .b_value(b_rd), .scale_en(scale_en),
      .alpha_scale(alpha_ff), .beta_scale(beta_ff), .c_old(c_rd),
      .sum_en(sum_en), .c_new(c_new));

   // ST_MAC: memories return the word for the previous p; ST_DRAIN takes the last,
   // ST_ACCW lets the registered product land in the accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ta_ff <= 1'b0;
         tb_ff <= 1'b0;
         rows_ff <= DIM_W'(16);
         cols_ff <= DIM_W'(16);
         inner_ff <= DIM_W'(16);
         alpha_ff <= 16'sd4096;
         beta_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
         i_ff <= '0;
         j_ff <= '0;
         p_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_type'(csr_index))
               CSR_TRANSPOSE_A: ta_ff <= csr_data[0];
               CSR_TRANSPOSE_B: tb_ff <= csr_data[0];
               CSR_ROWS_M:      rows_ff <= csr_data[DIM_W-1:0];
               CSR_COLS_N:      cols_ff <= csr_data[DIM_W-1:0];
               CSR_INNER_K:     inner_ff <= csr_data[DIM_W-1:0];
               CSR_ALPHA:       alpha_ff <= csr_data;
               CSR_BETA:        beta_ff <= csr_data;
               default: ;
            endcase
         end
         // read: c word arrives next cycle
         if (pend_ff) begin
            pend_ff <= 1'b0;
            rsp_valid_ff <= 1'b1;
            rsp_kind_ff <= RESULT_READ;
            rsp_value_ff <= read_zero_ff ? '0 : c_rd;
         end else if ((state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
            rsp_kind_ff <= RESULT_DONE;
            rsp_value_ff <= '0;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && (op_type'(req_operation) == OP_READ_C)) begin
                  pend_ff <= 1'b1;
                  read_zero_ff <= !in_range;
               end
               if (accept && (op_type'(req_operation) == OP_COMPUTE)) begin
                  state_ff <= ST_READ;
                  i_ff <= '0;
                  j_ff <= '0;
                  p_ff <= '0;
               end
            end
            ST_READ: begin
               if (last_p) state_ff <= ST_DRAIN;
               else begin
                  p_ff <= p_ff + DW'(1);
                  state_ff <= ST_MAC;
               end
            end
            ST_MAC: begin
               if (last_p) state_ff <= ST_DRAIN;
               else p_ff <= p_ff + DW'(1);
            end
            ST_DRAIN: state_ff <= ST_ACCW;
            ST_ACCW: state_ff <= ST_SCALE;
            ST_SCALE: state_ff <= ST_SUM;
            ST_SUM: state_ff <= ST_WRITE;
            ST_WRITE: begin
               p_ff <= '0;
               if (last_j) begin
                  j_ff <= '0;
                  if (last_i) state_ff <= ST_RESP;
                  else begin
                     i_ff <= i_ff + DW'(1);
                     state_ff <= ST_READ;
                  end
               end else begin
                  j_ff <= j_ff + DW'(1);
                  state_ff <= ST_READ;
               end
            end
            ST_RESP: begin
               if (!rsp_valid_ff || !rsp_stall) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_result_value = rsp_value_ff;

   // nothing is accepted while the sequencer runs
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !accept) else $error("accept during compute");
   // an accepted read always yields a pending response next cycle
   assert property (@(posedge clock) disable iff (reset)
      (accept && (op_type'(req_operation) == OP_READ_C)) |=> pend_ff)
      else $error("read lost");
   // a held response keeps its data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_result_value)))
      else $error("response changed under stall");
endmodule
